// File: rtl/assert_macros.svh
// Assertion macros shared by the spiral point generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SPG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be seen outside reset.
`define SPG_NEVER(lbl, clk, rst_n, expr, msg) \
    `SPG_ASSERT(lbl, clk, rst_n, !(expr), msg)

`endif

// File: rtl/spg_pkg.sv
// Package of the spiral point generator: widths, constants, tables and word types.
package spg_pkg;

    localparam int ROT_W       = 16;
    localparam int PPT_W       = 11;
    localparam int IDX_W       = 18;
    localparam int DATA_W      = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int MAX_PPT     = 1024;
    localparam int TOT_MAX     = (MAX_PPT * (2 ** ROT_W - 1)) / 256;
    localparam int T_W         = $clog2(TOT_MAX + 1);
    localparam int D_W         = T_W + 1;
    localparam int PHASE_SHIFT = 25;
    localparam int Q_W         = ROT_W + PHASE_SHIFT;
    localparam int NUM_W       = D_W + Q_W;
    localparam int GUARD       = 8;
    localparam int CW          = 42;
    localparam int AW          = 34;
    localparam int KINV_W      = 30;
    localparam logic [KINV_W-1:0] KINV = 30'h26DD3B6A;
    localparam int CORDIC_STAGES_DEF = 24;
    localparam int ATAN_N      = 32;

    localparam logic [ROT_W-1:0]  ROT_RST    = 16'd512;
    localparam logic [PPT_W-1:0]  PPT_RST    = 11'd32;
    localparam logic [DATA_W-1:0] START_RST  = 32'd65536;
    localparam logic [DATA_W-1:0] END_RST    = 32'd131072;
    localparam logic [DATA_W-1:0] HEIGHT_RST = 32'd131072;

    // Angle of each micro-rotation, atan(2^-k) in units of 2^-32 turn.
    localparam logic [31:0] ATAN_TURNS [ATAN_N] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROTATIONS = 3'd0,
        CFG_PPT       = 3'd1,
        CFG_START     = 3'd2,
        CFG_END       = 3'd3,
        CFG_HEIGHT    = 3'd4,
        CFG_REVERSE   = 3'd5
    } cfg_reg_t;

    // One lane of the long division: partial remainder, numerator bits shifting
    // out at the top and quotient bits shifting in at the bottom.
    typedef struct packed {
        logic [D_W-1:0] rem;
        logic [Q_W-1:0] low;
        logic           neg;
    } spg_lane_t;

    typedef struct packed {
        spg_lane_t      rad;
        spg_lane_t      hgt;
        spg_lane_t      phs;
        logic [D_W-1:0] den;
        logic           ok;
        logic           last;
    } spg_div_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [AW-1:0] ang;
        logic [DATA_W-1:0]    z;
        logic                 ok;
        logic                 last;
    } spg_rot_t;

endpackage

// File: rtl/spg_div_cell.sv
// One restoring division step for the radius, height and phase lanes.
module spg_div_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_v,
    input  spg_pkg::spg_div_t in_w,
    output logic              out_v,
    output spg_pkg::spg_div_t out_w
);

    localparam int D_W = spg_pkg::D_W;
    localparam int Q_W = spg_pkg::Q_W;

    spg_pkg::spg_div_t w_next;

    function automatic spg_pkg::spg_lane_t div_step(input spg_pkg::spg_lane_t l,
                                                    input logic [D_W-1:0] den);
        logic [D_W:0]       trial;
        logic [D_W:0]       diff;
        logic               fits;
        spg_pkg::spg_lane_t r;
        trial = {l.rem, l.low[Q_W-1]};
        diff  = trial - {1'b0, den};
        fits  = (trial >= {1'b0, den});
        r.neg = l.neg;
        r.rem = fits ? diff[D_W-1:0] : trial[D_W-1:0];
        r.low = {l.low[Q_W-2:0], fits};
        return r;
    endfunction

    always_comb
    begin
        w_next     = in_w;
        w_next.rad = div_step(in_w.rad, in_w.den);
        w_next.hgt = div_step(in_w.hgt, in_w.den);
        w_next.phs = div_step(in_w.phs, in_w.den);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v <= 1'b0;
        end
        else if (en)
        begin
            out_v <= in_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_w <= w_next;
        end
    end

endmodule

// File: rtl/spg_cordic_cell.sv
// One rotation-mode CORDIC micro-rotation with a fixed shift and angle step.
module spg_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_v,
    input  spg_pkg::spg_rot_t in_w,
    output logic              out_v,
    output spg_pkg::spg_rot_t out_w
);

    localparam int CW = spg_pkg::CW;
    localparam int AW = spg_pkg::AW;
    localparam logic signed [AW-1:0] STEP =
        $signed({{(AW-32){1'b0}}, spg_pkg::ATAN_TURNS[STAGE]});

    spg_pkg::spg_rot_t    w_next;
    logic signed [CW-1:0] x_cur;
    logic signed [CW-1:0] y_cur;
    logic signed [CW-1:0] x_sh;
    logic signed [CW-1:0] y_sh;
    logic signed [AW-1:0] a_cur;

    always_comb
    begin
        x_cur  = in_w.x;
        y_cur  = in_w.y;
        a_cur  = in_w.ang;
        x_sh   = x_cur >>> STAGE;
        y_sh   = y_cur >>> STAGE;
        w_next = in_w;
        if (a_cur >= 0)
        begin
            w_next.x   = x_cur - y_sh;
            w_next.y   = y_cur + x_sh;
            w_next.ang = a_cur - STEP;
        end
        else
        begin
            w_next.x   = x_cur + y_sh;
            w_next.y   = y_cur - x_sh;
            w_next.ang = a_cur + STEP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v <= 1'b0;
        end
        else if (en)
        begin
            out_v <= in_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_w <= w_next;
        end
    end

endmodule

// File: rtl/spiral_point_generator.sv
// Top level of the spiral point generator: config registers, pipeline and result register.
//
//   channel | handshake          | word
//   --------+--------------------+---------------------------------------------
//   cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
//   in      | in_valid/in_ready  | point_index
//   out     | out_valid/out_ready| pos_x, pos_y, pos_z, point_valid, final_point
//
// One word is accepted per cycle while the chain is not stalled; each word passes through
// the front stages, the division cells, one quotient bit each, the back stages and the
// CORDIC cells before its result is presented.
// The whole chain moves together and stops only when the result
// register is full and out_ready is low. cfg_ready is always high.
// Reset restores the register defaults and empties the chain.
`include "assert_macros.svh"

module spiral_point_generator #(
    parameter int CORDIC_STAGES = spg_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [spg_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [spg_pkg::DATA_W-1:0]           cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [spg_pkg::IDX_W-1:0]            point_index,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [spg_pkg::DATA_W-1:0]    pos_x,
    output logic signed [spg_pkg::DATA_W-1:0]    pos_y,
    output logic signed [spg_pkg::DATA_W-1:0]    pos_z,
    output logic                                 point_valid,
    output logic                                 final_point
);

    localparam int ROT_W   = spg_pkg::ROT_W;
    localparam int PPT_W   = spg_pkg::PPT_W;
    localparam int IDX_W   = spg_pkg::IDX_W;
    localparam int DATA_W  = spg_pkg::DATA_W;
    localparam int T_W     = spg_pkg::T_W;
    localparam int D_W     = spg_pkg::D_W;
    localparam int Q_W     = spg_pkg::Q_W;
    localparam int NUM_W   = spg_pkg::NUM_W;
    localparam int CW      = spg_pkg::CW;
    localparam int AW      = spg_pkg::AW;
    localparam int GUARD   = spg_pkg::GUARD;
    localparam int KINV_W  = spg_pkg::KINV_W;
    localparam int TP_W    = PPT_W + ROT_W;
    localparam int PR_W    = DATA_W + 1 + IDX_W + 1;
    localparam int PZ_W    = DATA_W + IDX_W + 1;
    localparam int PP_W    = IDX_W + ROT_W;
    localparam int PK_W    = DATA_W + KINV_W + 1;
    localparam int RSH     = KINV_W - GUARD;
    localparam logic signed [PK_W-1:0] R0_HALF = {{(PK_W-RSH){1'b0}}, 1'b1, {(RSH-1){1'b0}}};
    localparam logic signed [AW-1:0]   A_QTR   = {{(AW-31){1'b0}}, 1'b1, 30'd0};
    localparam logic signed [AW-1:0]   A_HALF  = {{(AW-32){1'b0}}, 1'b1, 31'd0};
    localparam logic signed [CW-1:0]   OUT_HALF = {{(CW-GUARD){1'b0}}, 1'b1, {(GUARD-1){1'b0}}};
    localparam logic signed [CW-1:0]   SAT_HI  = {{(CW-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [CW-1:0]   SAT_LO  = {{(CW-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

    // Configuration registers.
    logic [ROT_W-1:0]  rotations_reg;
    logic [PPT_W-1:0]  ppt_reg;
    logic [DATA_W-1:0] start_reg;
    logic [DATA_W-1:0] end_reg;
    logic [DATA_W-1:0] height_reg;
    logic              reverse_reg;

    // Point count, derived from the configuration.
    logic [PPT_W-1:0]  ppt_eff;
    logic [TP_W-1:0]   tot_prod;
    logic [TP_W-1:0]   tot_shift;
    logic [T_W-1:0]    total_next;
    logic [T_W-1:0]    total_reg;

    logic en;

    // Front stages.
    logic                    s0_v_reg;
    logic [IDX_W-1:0]        s0_idx_reg;
    logic                    s1_v_reg;
    logic                    s1_ok_reg;
    logic                    s1_last_reg;
    logic signed [PR_W-1:0]  s1_pr_reg;
    logic signed [PZ_W-1:0]  s1_pz_reg;
    logic [PP_W-1:0]         s1_pp_reg;
    logic signed [DATA_W:0]  rad_diff;
    logic signed [PR_W-1:0]  s1_pr_next;
    logic signed [PZ_W-1:0]  s1_pz_next;
    logic                    s2_v_reg;
    logic                    s2_ok_reg;
    logic                    s2_last_reg;
    logic signed [NUM_W:0]   s2_nr_reg;
    logic signed [NUM_W:0]   s2_nz_reg;
    logic [NUM_W-1:0]        s2_np_reg;
    logic signed [NUM_W:0]   s2_nr_next;
    logic signed [NUM_W:0]   s2_nz_next;
    logic [NUM_W-1:0]        s2_np_next;
    logic                    ld_v_reg;
    spg_pkg::spg_div_t       ld_w_reg;
    spg_pkg::spg_div_t       ld_w_next;
    logic [NUM_W:0]          mag_r;
    logic [NUM_W:0]          mag_z;

    // Division chain.
    logic [Q_W:0]            div_v;
    spg_pkg::spg_div_t       div_w [Q_W+1];
    spg_pkg::spg_div_t       dw;

    // Back stages.
    logic                    p1_v_reg;
    logic                    p1_ok_reg;
    logic                    p1_last_reg;
    logic [DATA_W-1:0]       p1_qr_reg;
    logic [DATA_W-1:0]       p1_z_reg;
    logic [DATA_W-1:0]       p1_ph_reg;
    logic [DATA_W-1:0]       p1_qr_next;
    logic [DATA_W-1:0]       p1_z_next;
    logic [DATA_W-1:0]       p1_ph_next;
    logic                    p2_v_reg;
    logic                    p2_ok_reg;
    logic                    p2_last_reg;
    logic signed [DATA_W-1:0] p2_r_reg;
    logic [DATA_W-1:0]       p2_z_reg;
    logic [DATA_W-1:0]       p2_ph_reg;
    logic                    p3_v_reg;
    logic                    p3_ok_reg;
    logic                    p3_last_reg;
    logic signed [PK_W-1:0]  p3_prod_reg;
    logic [DATA_W-1:0]       p3_z_reg;
    logic [DATA_W-1:0]       p3_ph_reg;
    logic                    p4_v_reg;
    logic                    p4_ok_reg;
    logic                    p4_last_reg;
    logic signed [CW-1:0]    p4_r0_reg;
    logic signed [AW-1:0]    p4_ang_reg;
    logic                    p4_flip_reg;
    logic [DATA_W-1:0]       p4_z_reg;
    logic signed [PK_W-1:0]  r0_round;
    logic signed [PK_W-1:0]  r0_shift;
    logic signed [AW-1:0]    ang_ext;
    logic signed [AW-1:0]    p4_ang_next;
    logic                    p4_flip_next;
    logic                    p5_v_reg;
    spg_pkg::spg_rot_t       p5_w_reg;
    spg_pkg::spg_rot_t       p5_w_next;

    // CORDIC chain.
    logic [CORDIC_STAGES:0]  rot_v;
    spg_pkg::spg_rot_t       rot_w [CORDIC_STAGES+1];
    spg_pkg::spg_rot_t       rw;

    // Result register.
    logic                    out_valid_reg;
    logic signed [DATA_W-1:0] pos_x_reg;
    logic signed [DATA_W-1:0] pos_y_reg;
    logic signed [DATA_W-1:0] pos_z_reg;
    logic                    point_valid_reg;
    logic                    final_point_reg;

    function automatic logic [DATA_W-1:0] round_sat(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] t;
        logic signed [CW-1:0] s;
        t = v + OUT_HALF;
        s = t >>> GUARD;
        if (s > SAT_HI)
        begin
            return SAT_HI[DATA_W-1:0];
        end
        else if (s < SAT_LO)
        begin
            return SAT_LO[DATA_W-1:0];
        end
        return s[DATA_W-1:0];
    endfunction

    assign cfg_ready = 1'b1;
    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotations_reg <= spg_pkg::ROT_RST;
            ppt_reg       <= spg_pkg::PPT_RST;
            start_reg     <= spg_pkg::START_RST;
            end_reg       <= spg_pkg::END_RST;
            height_reg    <= spg_pkg::HEIGHT_RST;
            reverse_reg   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (spg_pkg::cfg_reg_t'(cfg_index))
                spg_pkg::CFG_ROTATIONS: rotations_reg <= cfg_data[ROT_W-1:0];
                spg_pkg::CFG_PPT:       ppt_reg       <= cfg_data[PPT_W-1:0];
                spg_pkg::CFG_START:     start_reg     <= cfg_data;
                spg_pkg::CFG_END:       end_reg       <= cfg_data;
                spg_pkg::CFG_HEIGHT:    height_reg    <= cfg_data;
                spg_pkg::CFG_REVERSE:   reverse_reg   <= cfg_data[0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        if (ppt_reg == '0)
        begin
            ppt_eff = PPT_W'(1);
        end
        else if (ppt_reg > PPT_W'(spg_pkg::MAX_PPT))
        begin
            ppt_eff = PPT_W'(spg_pkg::MAX_PPT);
        end
        else
        begin
            ppt_eff = ppt_reg;
        end
        tot_prod   = TP_W'(ppt_eff) * TP_W'(rotations_reg);
        tot_shift  = tot_prod >> 8;
        total_next = (tot_shift == '0) ? T_W'(1) : tot_shift[T_W-1:0];
    end

    // The point count follows the registers in the cycle after they change; an item first
    // reads it when it moves from s0 into s1.
    always_ff @(posedge clk)
    begin
        total_reg <= total_next;
    end

    always_comb
    begin
        rad_diff   = $signed({end_reg[DATA_W-1], end_reg})
                   - $signed({start_reg[DATA_W-1], start_reg});
        s1_pr_next = PR_W'(rad_diff) * PR_W'($signed({1'b0, s0_idx_reg}));
        s1_pz_next = PZ_W'($signed(height_reg)) * PZ_W'($signed({1'b0, s0_idx_reg}));

        s2_nr_next = ((NUM_W+1)'(s1_pr_reg) <<< 1) + (NUM_W+1)'($signed({1'b0, total_reg}));
        s2_nz_next = ((NUM_W+1)'(s1_pz_reg) <<< 1) + (NUM_W+1)'($signed({1'b0, total_reg}));
        s2_np_next = (NUM_W'(s1_pp_reg) << spg_pkg::PHASE_SHIFT) + NUM_W'(total_reg);

        // Signed numerators are divided as magnitudes; the floor is restored later.
        mag_r = s2_nr_reg[NUM_W] ? 1'b0 - s2_nr_reg : s2_nr_reg;
        mag_z = s2_nz_reg[NUM_W] ? 1'b0 - s2_nz_reg : s2_nz_reg;
        ld_w_next.rad.rem = mag_r[NUM_W-1:Q_W];
        ld_w_next.rad.low = mag_r[Q_W-1:0];
        ld_w_next.rad.neg = s2_nr_reg[NUM_W];
        ld_w_next.hgt.rem = mag_z[NUM_W-1:Q_W];
        ld_w_next.hgt.low = mag_z[Q_W-1:0];
        ld_w_next.hgt.neg = s2_nz_reg[NUM_W];
        ld_w_next.phs.rem = s2_np_reg[NUM_W-1:Q_W];
        ld_w_next.phs.low = s2_np_reg[Q_W-1:0];
        ld_w_next.phs.neg = 1'b0;
        ld_w_next.den     = {total_reg, 1'b0};
        ld_w_next.ok      = s2_ok_reg;
        ld_w_next.last    = s2_last_reg;
    end

    assign div_v[0] = ld_v_reg;
    assign div_w[0] = ld_w_reg;

    for (genvar g = 0; g < Q_W; g++)
    begin : g_div
        spg_div_cell u_div_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .in_v  (div_v[g]),
            .in_w  (div_w[g]),
            .out_v (div_v[g+1]),
            .out_w (div_w[g+1])
        );
    end

    always_comb
    begin
        dw = div_w[Q_W];
        // For a negative numerator the floor is -(q + 1) when a remainder is left.
        p1_qr_next = dw.rad.neg ? (~dw.rad.low[DATA_W-1:0] + DATA_W'(dw.rad.rem == '0))
                                : dw.rad.low[DATA_W-1:0];
        p1_z_next  = dw.hgt.neg ? (~dw.hgt.low[DATA_W-1:0] + DATA_W'(dw.hgt.rem == '0))
                                : dw.hgt.low[DATA_W-1:0];
        p1_ph_next = reverse_reg ? dw.phs.low[DATA_W-1:0]
                                 : DATA_W'(0) - dw.phs.low[DATA_W-1:0];

        r0_round = p3_prod_reg + R0_HALF;
        r0_shift = r0_round >>> RSH;
        ang_ext  = AW'($signed(p3_ph_reg));
        // Fold the angle into the right half plane; the far half flips x.
        if (ang_ext > A_QTR)
        begin
            p4_ang_next  = ang_ext - A_HALF;
            p4_flip_next = 1'b1;
        end
        else if (ang_ext < -A_QTR)
        begin
            p4_ang_next  = ang_ext + A_HALF;
            p4_flip_next = 1'b1;
        end
        else
        begin
            p4_ang_next  = ang_ext;
            p4_flip_next = 1'b0;
        end

        p5_w_next.x    = p4_flip_reg ? -p4_r0_reg : p4_r0_reg;
        p5_w_next.y    = '0;
        p5_w_next.ang  = p4_ang_reg;
        p5_w_next.z    = p4_z_reg;
        p5_w_next.ok   = p4_ok_reg;
        p5_w_next.last = p4_last_reg;
    end

    assign rot_v[0] = p5_v_reg;
    assign rot_w[0] = p5_w_reg;

    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_cordic
        spg_cordic_cell #(
            .STAGE (g)
        ) u_cordic_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .in_v  (rot_v[g]),
            .in_w  (rot_w[g]),
            .out_v (rot_v[g+1]),
            .out_w (rot_w[g+1])
        );
    end

    assign rw = rot_w[CORDIC_STAGES];

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg      <= 1'b0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            ld_v_reg      <= 1'b0;
            p1_v_reg      <= 1'b0;
            p2_v_reg      <= 1'b0;
            p3_v_reg      <= 1'b0;
            p4_v_reg      <= 1'b0;
            p5_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_v_reg      <= in_valid;
            s1_v_reg      <= s0_v_reg;
            s2_v_reg      <= s1_v_reg;
            ld_v_reg      <= s2_v_reg;
            p1_v_reg      <= div_v[Q_W];
            p2_v_reg      <= p1_v_reg;
            p3_v_reg      <= p2_v_reg;
            p4_v_reg      <= p3_v_reg;
            p5_v_reg      <= p4_v_reg;
            out_valid_reg <= rot_v[CORDIC_STAGES];
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_idx_reg      <= point_index;

            s1_ok_reg       <= (rotations_reg != '0) && (s0_idx_reg <= total_reg);
            s1_last_reg     <= (s0_idx_reg == total_reg);
            s1_pr_reg       <= s1_pr_next;
            s1_pz_reg       <= s1_pz_next;
            s1_pp_reg       <= PP_W'(s0_idx_reg) * PP_W'(rotations_reg);

            s2_ok_reg       <= s1_ok_reg;
            s2_last_reg     <= s1_last_reg;
            s2_nr_reg       <= s2_nr_next;
            s2_nz_reg       <= s2_nz_next;
            s2_np_reg       <= s2_np_next;

            ld_w_reg        <= ld_w_next;

            p1_ok_reg       <= dw.ok;
            p1_last_reg     <= dw.last;
            p1_qr_reg       <= p1_qr_next;
            p1_z_reg        <= p1_z_next;
            p1_ph_reg       <= p1_ph_next;

            p2_ok_reg       <= p1_ok_reg;
            p2_last_reg     <= p1_last_reg;
            p2_r_reg        <= $signed(start_reg + p1_qr_reg);
            p2_z_reg        <= p1_z_reg;
            p2_ph_reg       <= p1_ph_reg;

            p3_ok_reg       <= p2_ok_reg;
            p3_last_reg     <= p2_last_reg;
            p3_prod_reg     <= PK_W'(p2_r_reg) * PK_W'($signed({1'b0, spg_pkg::KINV}));
            p3_z_reg        <= p2_z_reg;
            p3_ph_reg       <= p2_ph_reg;

            p4_ok_reg       <= p3_ok_reg;
            p4_last_reg     <= p3_last_reg;
            p4_r0_reg       <= r0_shift[CW-1:0];
            p4_ang_reg      <= p4_ang_next;
            p4_flip_reg     <= p4_flip_next;
            p4_z_reg        <= p3_z_reg;

            p5_w_reg        <= p5_w_next;

            pos_x_reg       <= rw.ok ? $signed(round_sat(rw.x)) : '0;
            pos_y_reg       <= rw.ok ? $signed(round_sat(rw.y)) : '0;
            pos_z_reg       <= rw.ok ? $signed(rw.z) : '0;
            point_valid_reg <= rw.ok;
            final_point_reg <= rw.ok && rw.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pos_x       = pos_x_reg;
    assign pos_y       = pos_y_reg;
    assign pos_z       = pos_z_reg;
    assign point_valid = point_valid_reg;
    assign final_point = final_point_reg;

    `SPG_ASSERT(a_last_needs_valid, clk, rst_n, out_valid && final_point |-> point_valid, "last point flagged on an invalid word")
    `SPG_ASSERT(a_invalid_is_zero, clk, rst_n, out_valid && !point_valid |-> (pos_x == '0) && (pos_y == '0) && (pos_z == '0), "invalid word carries nonzero coordinates")
    `SPG_NEVER(a_zero_divisor, clk, rst_n, div_v[0] && (div_w[0].den == '0), "division chain loaded with a zero divisor")

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench of the spiral point generator with a scoreboard class.
module testbench;

    localparam int  CFG_IDX_W   = spg_pkg::CFG_IDX_W;
    localparam int  DATA_W      = spg_pkg::DATA_W;
    localparam int  ROT_W       = spg_pkg::ROT_W;
    localparam int  PPT_W       = spg_pkg::PPT_W;
    localparam int  IDX_W       = spg_pkg::IDX_W;
    localparam int  GUARD       = spg_pkg::GUARD;
    localparam int  LATENCY     = 80;
    localparam int  WATCH_LIMIT = 5000;
    localparam int  LONG_HOLD   = 300;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
    localparam longint KINV_Q30 = 64'd652032874;

    typedef struct {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
        logic                     valid;
        logic                     last;
    } spiral_point_t;

    class spiral_scoreboard;
        logic [ROT_W-1:0]  rot;
        logic [PPT_W-1:0]  ppt;
        logic [DATA_W-1:0] r_start;
        logic [DATA_W-1:0] r_end;
        logic [DATA_W-1:0] height;
        logic              reverse;
        spiral_point_t     points_due[$];
        int                mismatches;
        int                checked;
        int                valid_seen;
        int                final_seen;

        function new();
            rot = spg_pkg::ROT_RST;
            ppt = spg_pkg::PPT_RST;
            r_start = spg_pkg::START_RST;
            r_end = spg_pkg::END_RST;
            height = spg_pkg::HEIGHT_RST;
            reverse = 1'b0;
            mismatches = 0;
            checked = 0;
            valid_seen = 0;
            final_seen = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
            case (idx)
                spg_pkg::CFG_ROTATIONS: rot = data[ROT_W-1:0];
                spg_pkg::CFG_PPT:       ppt = data[PPT_W-1:0];
                spg_pkg::CFG_START:     r_start = data;
                spg_pkg::CFG_END:       r_end = data;
                spg_pkg::CFG_HEIGHT:    height = data;
                spg_pkg::CFG_REVERSE:   reverse = data[0];
                default:                ;
            endcase
        endfunction

        function longint point_count();
            longint p;
            longint t;
            p = (ppt == 0) ? 1 : ((ppt > spg_pkg::MAX_PPT) ? spg_pkg::MAX_PPT : ppt);
            t = (p * rot) >>> 8;
            return (t == 0) ? 1 : t;
        endfunction

        function longint floor_div(longint n, longint d);
            longint q;
            q = n / d;
            if ((n % d) != 0 && n < 0)
                q = q - 1;
            return q;
        endfunction

        function logic signed [DATA_W-1:0] clamp(longint v);
            if (v > 64'sd2147483647)
                v = 64'sd2147483647;
            if (v < -64'sd2147483648)
                v = -64'sd2147483648;
            return v[DATA_W-1:0];
        endfunction

        function spiral_point_t compute_point(logic [IDX_W-1:0] idx);
            spiral_point_t p;
            longint t, i, r, z, x, y, a, nx, ny, st;
            longint unsigned num;
            logic [31:0] phase;
            p = '{x: 0, y: 0, z: 0, valid: 1'b0, last: 1'b0};
            t = point_count();
            i = idx;
            if (rot == 0 || i > t)
                return p;
            st = longint'($signed(r_start));
            r = st + floor_div(2 * (longint'($signed(r_end)) - st) * i + t, 2 * t);
            z = floor_div(2 * longint'($signed(height)) * i + t, 2 * t);
            num = (longint'(idx) * longint'(rot)) << 25;
            num = (num + t) / (2 * t);
            phase = num[31:0];
            if (!reverse)
                phase = -phase;
            x = (r * KINV_Q30 + (64'sd1 << (29 - GUARD))) >>> (30 - GUARD);
            y = 0;
            a = longint'($signed(phase));
            // Fold the angle into the right half plane before the micro-rotations.
            if (a > (64'sd1 <<< 30)) begin
                a = a - (64'sd1 <<< 31);
                x = -x;
            end else if (a < -(64'sd1 <<< 30)) begin
                a = a + (64'sd1 <<< 31);
                x = -x;
            end
            for (int k = 0; k < spg_pkg::CORDIC_STAGES_DEF; k++) begin
                if (a >= 0) begin
                    nx = x - (y >>> k);
                    ny = y + (x >>> k);
                    a = a - longint'(spg_pkg::ATAN_TURNS[k]);
                end else begin
                    nx = x + (y >>> k);
                    ny = y - (x >>> k);
                    a = a + longint'(spg_pkg::ATAN_TURNS[k]);
                end
                x = nx;
                y = ny;
            end
            p.x = clamp((x + (64'sd1 << (GUARD - 1))) >>> GUARD);
            p.y = clamp((y + (64'sd1 << (GUARD - 1))) >>> GUARD);
            p.z = clamp(z);
            p.valid = 1'b1;
            p.last = (i == t);
            return p;
        endfunction

        function void note_index(logic [IDX_W-1:0] idx);
            points_due.push_back(compute_point(idx));
        endfunction

        function void report(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: %s", what);
        endfunction

        function void check_point(spiral_point_t got);
            spiral_point_t exp_p;
            checked++;
            if (points_due.size() == 0) begin
                report("result word with no point outstanding");
                return;
            end
            exp_p = points_due.pop_front();
            if (got.valid)
                valid_seen++;
            if (got.last)
                final_seen++;
            if (got.x !== exp_p.x)
                report($sformatf("pos_x exp %0d got %0d", exp_p.x, got.x));
            if (got.y !== exp_p.y)
                report($sformatf("pos_y exp %0d got %0d", exp_p.y, got.y));
            if (got.z !== exp_p.z)
                report($sformatf("pos_z exp %0d got %0d", exp_p.z, got.z));
            if (got.valid !== exp_p.valid)
                report($sformatf("point_valid exp %0b got %0b", exp_p.valid, got.valid));
            if (got.last !== exp_p.last)
                report($sformatf("final_point exp %0b got %0b", exp_p.last, got.last));
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [DATA_W-1:0]        cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [IDX_W-1:0]         point_index = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] pos_z;
    logic                     point_valid;
    logic                     final_point;

    spiral_scoreboard sb = new();
    bit               no_idle = 1'b0;
    bit               hold_req = 1'b0;
    int               quiet_cycles = 0;
    int               phases_run = 0;

    spiral_point_generator i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .point_index(point_index),
        .out_valid(out_valid), .out_ready(out_ready),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .point_valid(point_valid), .final_point(final_point)
    );

    always #5 clk = ~clk;

    // Accepted words are noted at the edge, where all driven values are settled.
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (in_valid && in_ready)
                sb.note_index(point_index);
            if (out_valid && out_ready)
                sb.check_point('{x: pos_x, y: pos_y, z: pos_z,
                                 valid: point_valid, last: final_point});
            if ((cfg_valid && cfg_ready) || (in_valid && in_ready)
                    || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(posedge clk) begin
        if (quiet_cycles >= WATCH_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WATCH_LIMIT);
            $display("testbench failed");
            $finish;
        end
    end

    // Result side: random stalls per word, and one long hold-off on request.
    initial begin
        int gap;
        @(posedge rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            gap = no_idle ? 0 : $urandom_range(0, 15);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (sb.points_due.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic set_spiral(logic [15:0] rot, logic [10:0] ppt, logic [31:0] rs,
                              logic [31:0] re, logic [31:0] h, logic rev);
        wait_drained();
        write_reg(spg_pkg::CFG_ROTATIONS, DATA_W'(rot));
        write_reg(spg_pkg::CFG_PPT, DATA_W'(ppt));
        write_reg(spg_pkg::CFG_START, rs);
        write_reg(spg_pkg::CFG_END, re);
        write_reg(spg_pkg::CFG_HEIGHT, h);
        write_reg(spg_pkg::CFG_REVERSE, DATA_W'(rev));
        phases_run++;
    endtask

    task automatic send_points(logic [IDX_W-1:0] idx_list[$]);
        int gap;
        foreach (idx_list[n]) begin
            gap = no_idle ? 0 : $urandom_range(0, 15);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1'b1;
            point_index <= idx_list[n];
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
        end
        in_valid <= 1'b0;
    endtask

    // Mostly indexes on the spiral, some just past its end, some anywhere.
    task automatic send_random(int count);
        logic [IDX_W-1:0] idx_list[$];
        longint t;
        int pick;
        t = sb.point_count();
        repeat (count) begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                idx_list.push_back(IDX_W'($urandom_range(0, t)));
            else if (pick < 8)
                idx_list.push_back(IDX_W'(t + $urandom_range(0, 2)));
            else
                idx_list.push_back(IDX_W'($urandom_range(0, 2 ** IDX_W - 1)));
        end
        send_points(idx_list);
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: 64 points over two turns, including the final point.
        send_points('{0, 1, 16, 32, 63, 64, 65, 18'h3FFFF, 18'h20000, 18'h15555});
        send_random(20);

        // Zero rotations gives only invalid points.
        set_spiral(16'd0, 11'd32, 32'd65536, 32'd131072, 32'd65536, 1'b1);
        send_points('{0, 1, 18'h3FFFF});

        // Largest spiral with extreme radii so that the outputs saturate.
        set_spiral(16'hFFFF, 11'h7FF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1'b0);
        send_points('{0, 1, 131070, 262139, 262140, 262141, 18'h3FFFF});
        send_random(20);

        // A fraction of a turn with zero points per turn: a single segment.
        set_spiral(16'd1, 11'd0, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 1'b1);
        send_points('{0, 1, 2});

        // One full turn of the largest table, pipeline kept full and stalled hard.
        set_spiral(16'd256, 11'd1024, 32'hFFFF0000, 32'd6553600, 32'h80000000, 1'b1);
        write_reg(CFG_SPARE, 32'hFFFFFFFF);
        no_idle = 1'b1;
        hold_req = 1'b1;
        send_random(160);
        no_idle = 1'b0;

        repeat (6) begin
            set_spiral(16'($urandom_range(0, 65535)), 11'($urandom_range(0, 2047)), $urandom,
                       $urandom, $urandom, 1'($urandom_range(0, 1)));
            send_random(40);
        end

        wait_drained();
        if (sb.points_due.size() != 0)
            sb.report($sformatf("%0d points never returned", sb.points_due.size()));
        $display("covered %0d spiral settings, %0d results checked (%0d valid, %0d final)",
                 phases_run + 1, sb.checked, sb.valid_seen, sb.final_seen);
        $display("mismatches counted: %0d", sb.mismatches);
        if (sb.mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule
